[hdl/tama_pkg.sv]
// ----------------------------------------------------------------------------
// tama_pkg
// Shared constants and types for the three-axis moving-average unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tama_pkg;

    // Window length in samples.
    localparam int WINDOW = 8;

    // Slot index, window count (0..WINDOW), running-sum and step-counter widths.
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = 16 + $clog2(WINDOW);
    localparam int STEP_W = $clog2(SUM_W + 1);

    typedef struct packed {
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
    } rate_t;

    typedef struct packed {
        logic signed [15:0] avg_x;
        logic signed [15:0] avg_y;
        logic signed [15:0] avg_z;
    } avg_t;

    // Control from the sequencer to every lane.
    typedef struct packed {
        logic load;  // beat accepted: update window and sum, start division
        logic step;  // one restoring-division step
    } lane_ctrl_t;

endpackage : tama_pkg

`default_nettype wire

[hdl/tama_lane.sv]
// ----------------------------------------------------------------------------
// tama_lane
// One axis: sample window, running sum and a bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tama_lane (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tama_pkg::lane_ctrl_t          ctrl,
    input  wire logic signed [15:0]            sample,
    input  wire logic [tama_pkg::SLOT_W-1:0]   slot,
    input  wire logic [tama_pkg::CNT_W-1:0]    divisor,
    output logic signed [15:0]                 avg
);

    logic signed [15:0]                win_reg [tama_pkg::WINDOW];
    logic signed [tama_pkg::SUM_W-1:0] sum_reg;
    logic signed [tama_pkg::SUM_W-1:0] sum_next;
    logic [tama_pkg::SUM_W-1:0]        mag_next;
    logic [tama_pkg::SUM_W-1:0]        quo_reg;
    logic [tama_pkg::SUM_W-1:0]        quo_next;
    logic [tama_pkg::CNT_W-1:0]        rem_reg;
    logic [tama_pkg::CNT_W-1:0]        rem_next;
    logic [tama_pkg::CNT_W:0]          rem_shift;
    logic                              neg_reg;
    logic [15:0]                       quo16;

    always_comb
    begin
        sum_next = sum_reg + tama_pkg::SUM_W'(sample) - tama_pkg::SUM_W'(win_reg[slot]);
        mag_next = sum_next[tama_pkg::SUM_W-1] ? tama_pkg::SUM_W'(-sum_next)
                                               : tama_pkg::SUM_W'(sum_next);
    end

    // Restoring step: shift in next dividend bit, subtract if it fits.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[tama_pkg::SUM_W-1]};
        if (rem_shift >= {1'b0, divisor})
        begin
            rem_next = tama_pkg::CNT_W'(rem_shift - {1'b0, divisor});
            quo_next = {quo_reg[tama_pkg::SUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift[tama_pkg::CNT_W-1:0];
            quo_next = {quo_reg[tama_pkg::SUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tama_pkg::WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else if (ctrl.load)
        begin
            win_reg[slot] <= sample;
            sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            quo_reg <= mag_next;
            rem_reg <= '0;
            neg_reg <= sum_next[tama_pkg::SUM_W-1];
        end
        else if (ctrl.step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Quotient magnitude never exceeds 2^15; sign applied afterwards.
    assign quo16 = quo_reg[15:0];
    assign avg   = neg_reg ? -quo16 : quo16;

endmodule : tama_lane

`default_nettype wire

[hdl/three_axis_moving_average_unit.sv]
// ----------------------------------------------------------------------------
// three_axis_moving_average_unit
// Per-axis moving average of gyro rate samples with warm-up divisor.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload        | handshake
//  --------+-----------+----------------+---------------------------
//  sample  | in        | rate_x/y/z     | sample_valid, sample_stall
//  avg     | out       | avg_x/y/z      | avg_valid, avg_stall
//
//  One beat at a time: accept cycle, SUM_W divider steps (19 at WINDOW 8),
//  then the output register load; the next beat is taken only after that.
//  The step count is set by the bit-serial restoring divider in each lane.
//  Reset clears the windows, sums, slot pointer and fill flag at once.
//  A new sample beat is taken while a finished result still waits; a result
//  that is ready while the output register is full holds until avg_stall drops.
//
`default_nettype none

module three_axis_moving_average_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            sample_valid,
    output logic                 sample_stall,
    input  wire tama_pkg::rate_t sample,
    output logic                 avg_valid,
    input  wire logic            avg_stall,
    output tama_pkg::avg_t       avg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } state_t;

    state_t                           state_reg;
    logic [tama_pkg::SLOT_W-1:0]      slot_reg;
    logic                             filled_reg;
    logic [tama_pkg::CNT_W-1:0]       div_reg;
    logic [tama_pkg::STEP_W-1:0]      step_reg;
    logic                             out_valid_reg;
    tama_pkg::avg_t                   out_reg;

    logic                             accept;
    logic                             out_free;
    logic [tama_pkg::CNT_W-1:0]       slot_inc;
    logic                             wrap;
    logic [tama_pkg::CNT_W-1:0]       div_next;
    tama_pkg::lane_ctrl_t             ctrl;
    tama_pkg::avg_t                   lane_avg;

    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign out_free     = !out_valid_reg || !avg_stall;

    assign ctrl.load = accept;
    assign ctrl.step = (state_reg == S_DIV);

    // Slot advance; the divisor is the count after this beat, or WINDOW once full.
    always_comb
    begin
        slot_inc = tama_pkg::CNT_W'(slot_reg) + tama_pkg::CNT_W'(1);
        wrap     = (slot_inc == tama_pkg::CNT_W'(tama_pkg::WINDOW));
        if (filled_reg || wrap)
        begin
            div_next = tama_pkg::CNT_W'(tama_pkg::WINDOW);
        end
        else
        begin
            div_next = slot_inc;
        end
    end

    // One lane per axis
    tama_lane u_lane_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .sample  (sample.rate_x),
        .slot    (slot_reg),
        .divisor (div_reg),
        .avg     (lane_avg.avg_x)
    );

    tama_lane u_lane_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .sample  (sample.rate_y),
        .slot    (slot_reg),
        .divisor (div_reg),
        .avg     (lane_avg.avg_y)
    );

    tama_lane u_lane_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .sample  (sample.rate_z),
        .slot    (slot_reg),
        .divisor (div_reg),
        .avg     (lane_avg.avg_z)
    );

    // Sequencer plus merge into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            filled_reg    <= 1'b0;
            div_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Refill wins over drain when both happen at one edge
            if (state_reg == S_HOLD && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !avg_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        slot_reg   <= wrap ? '0 : slot_inc[tama_pkg::SLOT_W-1:0];
                        filled_reg <= filled_reg || wrap;
                        div_reg    <= div_next;
                        step_reg   <= '0;
                        state_reg  <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    step_reg <= step_reg + tama_pkg::STEP_W'(1);
                    if (step_reg == tama_pkg::STEP_W'(tama_pkg::SUM_W - 1))
                    begin
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_HOLD && out_free)
        begin
            out_reg <= lane_avg;
        end
    end

    assign avg_valid = out_valid_reg;
    assign avg       = out_reg;

endmodule : three_axis_moving_average_unit

`default_nettype wire
